// ----- design/ppcu_pkg.sv -----
// shared types and constants for the packed pattern cell unpacker
`default_nettype none

package ppcu_pkg;

	// size limits of a pattern
	localparam int MAX_CHANNELS = 32;
	localparam int MAX_ROWS     = 256;

	// channel and row counts saturate here
	localparam int CH_LIM  = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;
	localparam int ROW_LIM = (MAX_ROWS < 256) ? MAX_ROWS : 256;

	// register widths
	localparam int CH_CNT_W  = 6;
	localparam int ROW_CNT_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;

	// lead byte decoding
	localparam logic [4:0] MASK_FIELDS  = 5'h1F;
	localparam logic [4:0] PLAIN_FIELDS = 5'h1E;

	// note translation in packed cells
	localparam logic [7:0] NOTE_KEY_OFF_IN  = 8'd97;
	localparam logic [7:0] NOTE_KEY_OFF_OUT = 8'd255;
	localparam logic [7:0] NOTE_SHIFT       = 8'd12;

	// pending field mask bits
	localparam int FLD_NOTE  = 0;
	localparam int FLD_INSTR = 1;
	localparam int FLD_VOL   = 2;
	localparam int FLD_EFF   = 3;
	localparam int FLD_PARAM = 4;
	localparam int LEAD_PACKED_BIT = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT = 2'd0,
		REG_ROW_COUNT     = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		PH_LEAD    = 1'b0,
		PH_COLLECT = 1'b1
	} phase_t;

	typedef struct packed {
		logic [7:0] note;
		logic [7:0] instrument;
		logic [7:0] volume;
		logic [7:0] effect;
		logic [7:0] effect_param;
	} cell_data_t;

	typedef struct packed {
		logic [4:0] channel;
		logic [7:0] row;
		logic       last;
	} cell_pos_t;

endpackage

`default_nettype wire

// ----- design/packed_pattern_cell_unpacker_top.sv -----
// top level of the packed pattern cell unpacker
`default_nettype none

// Unpacks packed pattern data, one byte per item on the s_ side, into decoded
// cells on the m_ side, one cell per channel and row. A lead byte with bit 7
// set opens a packed cell whose mask bits 0..4 select note, instrument,
// volume, effect and parameter bytes that follow; absent fields read as zero
// and a packed note of 97 becomes 255 (key off), any other note gains 12.
// Any other lead byte is the note of a plain cell followed by four bytes.
// The block takes one byte every cycle unless input is held back as below: each
// byte is registered, decoded by a short field-collection state machine and,
// when a cell completes, written to the output register that drives m_tvalid.
// Input is held back only while a finished cell waits in the output register
// and the next byte would complete another one. m_tlast marks the final cell
// of the pattern, after which channel and row start from zero again. The user
// must write channel_count (index 0) and row_count (index 1) over the cfg port
// only while the block is idle; the block does not enforce this. Zero counts
// as one and counts above the limits saturate.
module packed_pattern_cell_unpacker_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// byte input
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [7:0]                          s_tdata,   // byte_value
	// cell output
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// note, instrument, volume, effect, effect_param, channel[4:0], row[7:0], 3 zero bits
	output logic [55:0]                              m_tdata,
	output logic                                     m_tlast,   // last_in_pattern
	// configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ppcu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ppcu_pkg::CFG_DAT_W-1:0]      cfg_data
);

	// configuration registers
	logic [ppcu_pkg::CH_CNT_W-1:0]  chan_count_q;
	logic [ppcu_pkg::ROW_CNT_W-1:0] row_count_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// output stage
	logic                 out_valid_s2;
	ppcu_pkg::cell_data_t out_data_s2;
	ppcu_pkg::cell_pos_t  out_pos_s2;

	logic                 emit;
	logic                 out_free;
	logic                 advance;
	ppcu_pkg::cell_data_t cell_data;
	ppcu_pkg::cell_pos_t  cell_pos;

	// registers always accept writes, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= ppcu_pkg::CH_CNT_W'(4);
			row_count_q  <= ppcu_pkg::ROW_CNT_W'(64);
		end else if (cfg_valid) begin
			case (cfg_index)
				ppcu_pkg::REG_CHANNEL_COUNT: chan_count_q <= cfg_data[ppcu_pkg::CH_CNT_W-1:0];
				ppcu_pkg::REG_ROW_COUNT:     row_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// the staged byte moves on unless it finishes a cell that has nowhere to go
	assign out_free = !out_valid_s2 || m_tready;
	assign advance  = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	ppcu_collect u_collect (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.byte_value (byte_s1),
		.emit       (emit),
		.data       (cell_data)
	);

	// position moves only when a cell is handed on
	ppcu_position u_position (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance && emit),
		.channel_count (chan_count_q),
		.row_count     (row_count_q),
		.pos           (cell_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_s2 <= cell_data;
			out_pos_s2  <= cell_pos;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tlast  = out_pos_s2.last;
	assign m_tdata  = {3'b000, out_pos_s2.row, out_pos_s2.channel,
		out_data_s2.effect_param, out_data_s2.effect, out_data_s2.volume,
		out_data_s2.instrument, out_data_s2.note};

	// a finished pattern restarts at channel zero, row zero
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && cell_pos.last |=> cell_pos.channel == 5'd0 && cell_pos.row == 8'd0)
		else $error("position did not restart after last cell");

	// an empty input stage never holds off the source
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty stage");

	// every finished cell shows up on the output
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> m_tvalid)
		else $error("finished cell not presented");

endmodule

`default_nettype wire

// ----- design/ppcu_collect.sv -----
// field collection state machine: lead byte decode and per-field capture
`default_nettype none

module ppcu_collect (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           byte_value,
	output logic                      emit,
	output ppcu_pkg::cell_data_t      data
);

	ppcu_pkg::phase_t phase_q, phase_d;
	logic [4:0] pending_q, pending_d, pend_upd;
	logic [7:0] note_q, instr_q, vol_q, eff_q;
	logic [7:0] note_upd, instr_upd, vol_upd, eff_upd, param_upd;
	logic [7:0] note_d, instr_d, vol_d, eff_d;

	// working values after this byte, before a finished cell clears them
	always_comb begin
		pend_upd  = pending_q;
		note_upd  = note_q;
		instr_upd = instr_q;
		vol_upd   = vol_q;
		eff_upd   = eff_q;
		param_upd = 8'd0;
		emit      = 1'b0;
		case (phase_q)
			ppcu_pkg::PH_LEAD: begin
				note_upd  = 8'd0;
				instr_upd = 8'd0;
				vol_upd   = 8'd0;
				eff_upd   = 8'd0;
				if (byte_value[ppcu_pkg::LEAD_PACKED_BIT]) begin
					pend_upd = byte_value[4:0] & ppcu_pkg::MASK_FIELDS;
					emit     = (pend_upd == 5'd0);
				end else begin
					note_upd = byte_value;
					pend_upd = ppcu_pkg::PLAIN_FIELDS;
				end
			end
			ppcu_pkg::PH_COLLECT: begin
				if (pending_q[ppcu_pkg::FLD_NOTE]) begin
					pend_upd[ppcu_pkg::FLD_NOTE] = 1'b0;
					note_upd = (byte_value == ppcu_pkg::NOTE_KEY_OFF_IN) ?
						ppcu_pkg::NOTE_KEY_OFF_OUT : byte_value + ppcu_pkg::NOTE_SHIFT;
				end else if (pending_q[ppcu_pkg::FLD_INSTR]) begin
					pend_upd[ppcu_pkg::FLD_INSTR] = 1'b0;
					instr_upd = byte_value;
				end else if (pending_q[ppcu_pkg::FLD_VOL]) begin
					pend_upd[ppcu_pkg::FLD_VOL] = 1'b0;
					vol_upd = byte_value;
				end else if (pending_q[ppcu_pkg::FLD_EFF]) begin
					pend_upd[ppcu_pkg::FLD_EFF] = 1'b0;
					eff_upd = byte_value;
				end else if (pending_q[ppcu_pkg::FLD_PARAM]) begin
					pend_upd  = 5'd0;
					param_upd = byte_value;
				end
				emit = (pend_upd == 5'd0);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// cell fields as handed out
	always_comb begin
		data.note         = note_upd;
		data.instrument   = instr_upd;
		data.volume       = vol_upd;
		data.effect       = eff_upd;
		data.effect_param = param_upd;
	end

	// next state: a finished cell returns to the lead byte with everything cleared
	always_comb begin
		if (emit) begin
			phase_d   = ppcu_pkg::PH_LEAD;
			pending_d = 5'd0;
			note_d    = 8'd0;
			instr_d   = 8'd0;
			vol_d     = 8'd0;
			eff_d     = 8'd0;
		end else begin
			phase_d   = ppcu_pkg::PH_COLLECT;
			pending_d = pend_upd;
			note_d    = note_upd;
			instr_d   = instr_upd;
			vol_d     = vol_upd;
			eff_d     = eff_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ppcu_pkg::PH_LEAD;
			pending_q <= 5'd0;
			note_q    <= 8'd0;
			instr_q   <= 8'd0;
			vol_q     <= 8'd0;
			eff_q     <= 8'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			pending_q <= pending_d;
			note_q    <= note_d;
			instr_q   <= instr_d;
			vol_q     <= vol_d;
			eff_q     <= eff_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/ppcu_position.sv -----
// channel and row counters with pattern end detection
`default_nettype none

module ppcu_position (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                step,
	input  wire logic [ppcu_pkg::CH_CNT_W-1:0]       channel_count,
	input  wire logic [ppcu_pkg::ROW_CNT_W-1:0]      row_count,
	output ppcu_pkg::cell_pos_t                      pos
);

	logic [4:0] chan_q;
	logic [7:0] row_q;
	logic [ppcu_pkg::CH_CNT_W-1:0]  eff_ch;
	logic [ppcu_pkg::ROW_CNT_W-1:0] eff_rows;
	logic row_end, pat_end;

	// zero counts as one, large counts saturate
	always_comb begin
		if (channel_count == '0)
			eff_ch = ppcu_pkg::CH_CNT_W'(1);
		else if (channel_count > ppcu_pkg::CH_CNT_W'(ppcu_pkg::CH_LIM))
			eff_ch = ppcu_pkg::CH_CNT_W'(ppcu_pkg::CH_LIM);
		else
			eff_ch = channel_count;
		if (row_count == '0)
			eff_rows = ppcu_pkg::ROW_CNT_W'(1);
		else if (row_count > ppcu_pkg::ROW_CNT_W'(ppcu_pkg::ROW_LIM))
			eff_rows = ppcu_pkg::ROW_CNT_W'(ppcu_pkg::ROW_LIM);
		else
			eff_rows = row_count;
	end

	// at or past the last position counts as the last one
	assign row_end = (ppcu_pkg::CH_CNT_W'(chan_q) + ppcu_pkg::CH_CNT_W'(1)) >= eff_ch;
	assign pat_end = (ppcu_pkg::ROW_CNT_W'(row_q) + ppcu_pkg::ROW_CNT_W'(1)) >= eff_rows;

	assign pos.channel = chan_q;
	assign pos.row     = row_q;
	assign pos.last    = row_end && pat_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= 5'd0;
			row_q  <= 8'd0;
		end else if (step) begin
			if (!row_end) begin
				chan_q <= chan_q + 5'd1;
			end else begin
				chan_q <= 5'd0;
				row_q  <= pat_end ? 8'd0 : row_q + 8'd1;
			end
		end
	end

endmodule

`default_nettype wire
